// ===== design/http_request_header_parser_macros.svh =====
// assertion macros for the http request header parser checks
// expects clk and arst_n in the scope where a macro is used
`ifndef HTTP_REQUEST_HEADER_PARSER_MACROS_SVH
`define HTTP_REQUEST_HEADER_PARSER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HRP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hrp check failed");

// next-cycle implication, disabled while in reset
`define HRP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hrp check failed");

`endif

// ===== design/hrp_pkg.sv =====
// shared types for the http request header parser
// status and byte kind codes and the per-request result record; no dependencies
`default_nettype none

package hrp_pkg;

	// parse status reported with each request
	typedef enum logic [1:0] {
		STAT_NEED  = 2'd0,
		STAT_DONE  = 2'd1,
		STAT_ERROR = 2'd2
	} status_t;

	// role of the byte in the request
	typedef enum logic [2:0] {
		KIND_NONE    = 3'd0,
		KIND_METHOD  = 3'd1,
		KIND_URI     = 3'd2,
		KIND_NEWNAME = 3'd3,
		KIND_NAME    = 3'd4,
		KIND_VALUE   = 3'd5
	} kind_t;

	// one result record
	typedef struct packed {
		logic [15:0] version_minor;
		logic [15:0] version_major;
		kind_t       byte_kind;
		status_t     status;
	} result_t;

	// padded width of the output tdata bus
	localparam int unsigned OUT_TDATA_W = 40;

endpackage

`default_nettype wire

// ===== design/hrp_core.sv =====
// parser state machine: holds parse state and version counters, decodes one byte
// depends on hrp_pkg for status, kind and result types
`default_nettype none

module hrp_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             action,
	input  wire logic [7:0]       data_byte,
	output hrp_pkg::result_t      res
);

	typedef enum logic [4:0] {
		S_METHOD_START = 5'd0,
		S_METHOD       = 5'd1,
		S_URI          = 5'd2,
		S_VER_H        = 5'd3,
		S_VER_T1       = 5'd4,
		S_VER_T2       = 5'd5,
		S_VER_P        = 5'd6,
		S_VER_SLASH    = 5'd7,
		S_MAJOR_START  = 5'd8,
		S_MAJOR        = 5'd9,
		S_MINOR_START  = 5'd10,
		S_MINOR        = 5'd11,
		S_LF_1         = 5'd12,
		S_LINE_START   = 5'd13,
		S_LWS          = 5'd14,
		S_NAME         = 5'd15,
		S_SPACE_VALUE  = 5'd16,
		S_VALUE        = 5'd17,
		S_LF_2         = 5'd18,
		S_LF_3         = 5'd19
	} state_t;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_MAXC  = 8'h1F;
	localparam logic [15:0] VER_MAX = 16'hFFFF;

	// http separator characters
	function automatic logic is_special(input logic [7:0] c);
		logic r;
		unique case (c)
			8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40,
			8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
			8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D,
			8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
			default:                    r = 1'b0;
		endcase
		return r;
	endfunction

	// control characters; bytes above 127 are not controls
	function automatic logic is_ctl(input logic [7:0] c);
		return (c <= CH_MAXC) || (c == CH_DEL);
	endfunction

	function automatic logic is_token(input logic [7:0] c);
		return !c[7] && !is_ctl(c) && !is_special(c);
	endfunction

	// value * 10 + digit, saturating at the 16-bit maximum
	function automatic logic [15:0] add_digit(input logic [15:0] v, input logic [3:0] d);
		logic [19:0] r;
		r = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {16'd0, d};
		return (r > {4'd0, VER_MAX}) ? VER_MAX : r[15:0];
	endfunction

	state_t          state_q;
	logic            seen_q;
	logic [15:0]     major_q;
	logic [15:0]     minor_q;

	state_t          state_nxt;
	logic            seen_nxt;
	logic [15:0]     major_nxt;
	logic [15:0]     minor_nxt;
	logic            err;
	logic            done;
	hrp_pkg::kind_t  kind;
	logic            is_dig;
	logic            is_ws;

	assign is_dig = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign is_ws  = (data_byte == CH_SP) || (data_byte == CH_TAB);

	// next-state decode for one data byte
	always_comb begin
		state_nxt = state_q;
		seen_nxt  = seen_q;
		major_nxt = major_q;
		minor_nxt = minor_q;
		err       = 1'b0;
		done      = 1'b0;
		kind      = hrp_pkg::KIND_NONE;
		unique case (state_q)
			S_METHOD_START: begin
				if (is_token(data_byte)) begin
					state_nxt = S_METHOD;
					kind      = hrp_pkg::KIND_METHOD;
				end else err = 1'b1;
			end
			S_METHOD: begin
				if (data_byte == CH_SP) state_nxt = S_URI;
				else if (is_token(data_byte)) kind = hrp_pkg::KIND_METHOD;
				else err = 1'b1;
			end
			S_URI: begin
				if (data_byte == CH_SP) state_nxt = S_VER_H;
				else if (is_ctl(data_byte)) err = 1'b1;
				else kind = hrp_pkg::KIND_URI;
			end
			S_VER_H: begin
				if (data_byte == CH_H) state_nxt = S_VER_T1; else err = 1'b1;
			end
			S_VER_T1: begin
				if (data_byte == CH_T) state_nxt = S_VER_T2; else err = 1'b1;
			end
			S_VER_T2: begin
				if (data_byte == CH_T) state_nxt = S_VER_P; else err = 1'b1;
			end
			S_VER_P: begin
				if (data_byte == CH_P) state_nxt = S_VER_SLASH; else err = 1'b1;
			end
			S_VER_SLASH: begin
				if (data_byte == CH_SLASH) begin
					major_nxt = '0;
					minor_nxt = '0;
					state_nxt = S_MAJOR_START;
				end else err = 1'b1;
			end
			S_MAJOR_START: begin
				if (is_dig) begin
					major_nxt = add_digit(major_q, data_byte[3:0]);
					state_nxt = S_MAJOR;
				end else err = 1'b1;
			end
			S_MAJOR: begin
				if (data_byte == CH_DOT) state_nxt = S_MINOR_START;
				else if (is_dig) major_nxt = add_digit(major_q, data_byte[3:0]);
				else err = 1'b1;
			end
			S_MINOR_START: begin
				if (is_dig) begin
					minor_nxt = add_digit(minor_q, data_byte[3:0]);
					state_nxt = S_MINOR;
				end else err = 1'b1;
			end
			S_MINOR: begin
				if (data_byte == CH_CR) state_nxt = S_LF_1;
				else if (is_dig) minor_nxt = add_digit(minor_q, data_byte[3:0]);
				else err = 1'b1;
			end
			S_LF_1: begin
				if (data_byte == CH_LF) state_nxt = S_LINE_START; else err = 1'b1;
			end
			S_LINE_START: begin
				if (data_byte == CH_CR) state_nxt = S_LF_3;
				else if (seen_q && is_ws) state_nxt = S_LWS;
				else if (is_token(data_byte)) begin
					seen_nxt  = 1'b1;
					state_nxt = S_NAME;
					kind      = hrp_pkg::KIND_NEWNAME;
				end else err = 1'b1;
			end
			S_LWS: begin
				if (data_byte == CH_CR) state_nxt = S_LF_2;
				else if (is_ws) state_nxt = S_LWS;
				else if (is_ctl(data_byte)) err = 1'b1;
				else begin
					state_nxt = S_VALUE;
					kind      = hrp_pkg::KIND_VALUE;
				end
			end
			S_NAME: begin
				if (data_byte == CH_COLON) state_nxt = S_SPACE_VALUE;
				else if (is_token(data_byte)) kind = hrp_pkg::KIND_NAME;
				else err = 1'b1;
			end
			S_SPACE_VALUE: begin
				if (data_byte == CH_SP) state_nxt = S_VALUE; else err = 1'b1;
			end
			S_VALUE: begin
				if (data_byte == CH_CR) state_nxt = S_LF_2;
				else if (is_ctl(data_byte)) err = 1'b1;
				else kind = hrp_pkg::KIND_VALUE;
			end
			S_LF_2: begin
				if (data_byte == CH_LF) state_nxt = S_LINE_START; else err = 1'b1;
			end
			S_LF_3: begin
				if (data_byte == CH_LF) done = 1'b1; else err = 1'b1;
			end
			default: err = 1'b1;
		endcase
	end

	// result for this request: restart and error leave the counters as they are
	always_comb begin
		res.version_major = major_q;
		res.version_minor = minor_q;
		res.byte_kind     = hrp_pkg::KIND_NONE;
		res.status        = hrp_pkg::STAT_NEED;
		if (!action) begin
			if (err) begin
				res.status = hrp_pkg::STAT_ERROR;
			end else begin
				res.version_major = major_nxt;
				res.version_minor = minor_nxt;
				res.byte_kind     = kind;
				res.status        = done ? hrp_pkg::STAT_DONE : hrp_pkg::STAT_NEED;
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_METHOD_START;
			seen_q  <= 1'b0;
			major_q <= '0;
			minor_q <= '0;
		end else if (en) begin
			if (action) begin
				state_q <= S_METHOD_START;
				seen_q  <= 1'b0;
			end else if (!err) begin
				state_q <= state_nxt;
				seen_q  <= seen_nxt;
				major_q <= major_nxt;
				minor_q <= minor_nxt;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/http_request_header_parser.sv =====
// each byte passes the input stage and hrp_core, then the output register drives m_tdata
// throughput: one byte per cycle unless m_tready stalls a full output register
// the output register holds a stalled result; the input stage takes one more byte if empty
// reset: asynchronous, active low; parser returns to method start, versions read zero
// top level: input stage, parser core and output register; depends on hrp_pkg, hrp_core
`default_nettype none

module http_request_header_parser (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [7:0]                          s_tdata, // data_byte
	input  wire logic                                s_tuser, // action
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// status [1:0], byte_kind [4:2], version_major [20:5], version_minor [36:21], zero pad
	output logic [hrp_pkg::OUT_TDATA_W-1:0]          m_tdata
);

	localparam int unsigned RES_W = $bits(hrp_pkg::result_t);

	logic              valid_s1;
	logic              action_s1;
	logic [7:0]        byte_s1;
	logic              valid_s2;
	hrp_pkg::result_t  res_s2;
	hrp_pkg::result_t  res;
	logic              advance;

	// stage 1 moves on when the output register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser;
			byte_s1   <= s_tdata;
		end
	end

	hrp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.action    (action_s1),
		.data_byte (byte_s1),
		.res       (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(hrp_pkg::OUT_TDATA_W - RES_W){1'b0}}, res_s2};

endmodule

`default_nettype wire

// ===== design/hrp_checker.sv =====
// port-level checks for the http request header parser, bound to the top level
// depends on hrp_pkg and http_request_header_parser_macros.svh
`default_nettype none

`include "http_request_header_parser_macros.svh"

module hrp_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        s_tvalid,
	input wire logic                        s_tready,
	input wire logic                        m_tvalid,
	input wire logic                        m_tready,
	input wire logic [hrp_pkg::OUT_TDATA_W-1:0] m_tdata
);

	// a stalled result holds
	`HRP_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// an empty output register never blocks the input side
	`HRP_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready)

	// error results carry no byte role
	`HRP_ASSERT_IMP(a_err_kind, m_tvalid && (m_tdata[1:0] == hrp_pkg::STAT_ERROR),
		m_tdata[4:2] == hrp_pkg::KIND_NONE)

	// end of headers is reported on a delimiter byte
	`HRP_ASSERT_IMP(a_done_kind, m_tvalid && (m_tdata[1:0] == hrp_pkg::STAT_DONE),
		m_tdata[4:2] == hrp_pkg::KIND_NONE)

endmodule

bind http_request_header_parser hrp_checker u_hrp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
